[sv/rmts_pkg.sv]
// Shared types and constants of the rate-monotonic tick scheduler.
// Slot record layout, result item layout and beat codes.
// No dependencies.
package rmts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 112;

    // s_tuser codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // m_tuser codes
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_SEGMENT = 1'b1;

    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] arrival;
        logic [15:0] period;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [15:0] response;
    } slot_rec_t;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [7:0]  task_id;
        logic        idle;
        logic [15:0] seg_start;
        logic [15:0] seg_end;
        logic        task_done;
        logic [15:0] completion;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic [15:0] response;
        logic        all_done;
    } res_item_t;

    // Results of one tick: [0] segment closed by switch or idle,
    // [1] segment closed by completion, [2] status.
    typedef struct packed {
        logic [2:0]      vld;
        res_item_t [2:0] item;
    } res_batch_t;

endpackage

[sv/rmts_result_queue.sv]
// Result staging for the scheduler: holds the beats of one tick and
// hands them out in order through a master-side output register.
// Depends on rmts_pkg.
module rmts_result_queue
    import rmts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  res_batch_t             batch,
    output logic                   drained,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // task_id, idle, seg_start, seg_end, task_done, completion,
    // turnaround, waiting, response, all_done, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // kind
    output logic                   m_tuser,
    output logic                   m_tlast
);

    logic [2:0]      pend_vld_reg, pend_vld_next;
    res_item_t [2:0] pend_reg, pend_next;
    logic            out_vld_reg, out_vld_next;
    res_item_t       out_reg, out_next;
    logic            out_free;
    logic [1:0]      sel;

    assign out_free = !out_vld_reg || m_tready;
    assign drained  = (pend_vld_reg == 3'b000);

    always_comb
    begin
        if (pend_vld_reg[0])
        begin
            sel = 2'd0;
        end
        else if (pend_vld_reg[1])
        begin
            sel = 2'd1;
        end
        else
        begin
            sel = 2'd2;
        end
    end

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (load)
        begin
            pend_vld_next = batch.vld;
            pend_next     = batch.item;
        end
        else if (out_free && !drained)
        begin
            out_next           = pend_reg[sel];
            out_vld_next       = 1'b1;
            pend_vld_next[sel] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 3'b000;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'b00000, out_reg.all_done, out_reg.response, out_reg.waiting,
                       out_reg.turnaround, out_reg.completion, out_reg.task_done,
                       out_reg.seg_end, out_reg.seg_start, out_reg.idle, out_reg.task_id};

endmodule

[sv/rate_monotonic_tick_scheduler.sv]
// Rate-monotonic tick scheduler, top level. Task table in one synchronous RAM.
// Load beat: taken while idle, no result. Tick beat with n slots in use:
// a table scan of n RAM reads (one RAM read a cycle), decide, finish, then one
// to three result beats at one a cycle while the output does not stall; a new
// beat is taken only after every result beat has moved to the output register.
// Reset clears the clock, segment tracking and started/finished flags; table
// contents are undefined until a slot is loaded. Depends on rmts_pkg.
module rate_monotonic_tick_scheduler
    import rmts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // slot, task_ident, arrival, period_len, burst, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // task_id, idle, seg_start, seg_end, task_done, completion,
    // turnaround, waiting, response, all_done, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // kind
    output logic                   m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [4:0]             cfg_wr_data
);

    localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNTW = $clog2(MAX_TASKS + 1);
    localparam int CW   = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_FIN    = 5'b01000,
        ST_DRAIN  = 5'b10000
    } state_t;

    function automatic logic [CW-1:0] sub_floor(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    // beat fields
    logic [3:0]  in_slot;
    logic [7:0]  in_ident;
    logic [15:0] in_arrival;
    logic [15:0] in_period;
    logic [15:0] in_burst;

    assign in_slot    = s_tdata[3:0];
    assign in_ident   = s_tdata[11:4];
    assign in_arrival = s_tdata[27:12];
    assign in_period  = s_tdata[43:28];
    assign in_burst   = s_tdata[59:44];

    // task table
    slot_rec_t      mem [MAX_TASKS];
    slot_rec_t      rd_data_reg;
    logic [IW-1:0]  rd_addr;
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    slot_rec_t      wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // registers
    state_t                 state_reg, state_next;
    logic [4:0]             task_count_reg;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic                   prev_valid_reg, prev_valid_next;
    logic [7:0]             prev_ident_reg, prev_ident_next;
    logic [TIME_BITS-1:0]   seg_begin_reg, seg_begin_next;
    logic [MAX_TASKS-1:0]   started_reg, started_next;
    logic [MAX_TASKS-1:0]   finished_reg, finished_next;
    logic [CNTW-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [CNTW-1:0]        unf_cnt_reg, unf_cnt_next;
    logic                   found_reg, found_next;
    slot_rec_t              best_reg, best_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic                   done_reg, done_next;
    logic                   all_done_reg, all_done_next;
    res_batch_t             batch_reg, batch_next;

    // helpers
    logic [31:0]            tc_ext;
    logic [CNTW-1:0]        n_cnt;
    logic                   accept;
    logic                   issue;
    logic [8:0]             slot_wide;
    logic                   slot_ok;
    logic                   cmp_unf;
    logic                   better;
    logic [TIME_BITS-1:0]   now_inc;
    logic                   switch_seg;
    logic                   seg_a_vld;
    logic [TIME_BITS-1:0]   seg_begin_run;
    logic [15:0]            rem_new;
    logic                   done_now;
    logic [15:0]            resp_new;
    slot_rec_t              rec_new;
    res_item_t              seg_a, seg_b, status;
    logic [CW-1:0]          tat, wt;
    logic                   q_load;
    res_batch_t             q_batch;
    logic                   q_drained;

    assign tc_ext = 32'(task_count_reg);
    assign n_cnt  = (tc_ext > 32'(MAX_TASKS)) ? CNTW'(MAX_TASKS) : CNTW'(task_count_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign issue     = (state_reg == ST_SCAN) && (scan_cnt_reg < n_cnt);
    assign rd_addr   = scan_cnt_reg[IW-1:0];
    assign slot_wide = 9'(in_slot);
    assign slot_ok   = (32'(in_slot) < 32'(MAX_TASKS));

    // scan compare stage, one RAM word a cycle
    assign cmp_unf = !finished_reg[cmp_idx_reg];
    assign better  = cmp_vld_reg && cmp_unf
                     && (CW'(rd_data_reg.arrival) <= CW'(now_reg))
                     && (!found_reg || (rd_data_reg.period < best_reg.period));

    // tick decision on the winner
    assign now_inc       = (now_reg == TIME_MAX) ? now_reg : now_reg + TIME_BITS'(1);
    assign switch_seg    = found_reg && prev_valid_reg && (prev_ident_reg != best_reg.ident);
    assign seg_a_vld     = switch_seg || (!found_reg && prev_valid_reg);
    assign seg_begin_run = (!prev_valid_reg || switch_seg) ? now_reg : seg_begin_reg;
    assign rem_new       = (best_reg.remaining != 16'd0) ? best_reg.remaining - 16'd1 : 16'd0;
    assign done_now      = found_reg && (rem_new == 16'd0);
    assign resp_new      = started_reg[best_idx_reg] ? best_reg.response
                           : 16'(sub_floor(CW'(now_reg), CW'(best_reg.arrival)));

    always_comb
    begin
        rec_new           = best_reg;
        rec_new.remaining = rem_new;
        rec_new.response  = resp_new;

        seg_a           = '0;
        seg_a.kind      = KIND_SEGMENT;
        seg_a.task_id   = prev_ident_reg;
        seg_a.seg_start = 16'(seg_begin_reg);
        seg_a.seg_end   = 16'(now_reg);

        seg_b           = '0;
        seg_b.kind      = KIND_SEGMENT;
        seg_b.task_id   = best_reg.ident;
        seg_b.seg_start = 16'(seg_begin_run);
        seg_b.seg_end   = 16'(now_inc);
    end

    // status figures; now_reg already holds the completion tick here
    assign tat = sub_floor(CW'(now_reg), CW'(best_reg.arrival));
    assign wt  = sub_floor(tat, CW'(best_reg.burst));

    always_comb
    begin
        status            = '0;
        status.kind       = KIND_STATUS;
        status.last       = 1'b1;
        status.task_id    = found_reg ? best_reg.ident : 8'd0;
        status.idle       = !found_reg;
        status.task_done  = done_reg;
        status.all_done   = all_done_reg;
        if (done_reg)
        begin
            status.completion = 16'(now_reg);
            status.turnaround = 16'(tat);
            status.waiting    = 16'(wt);
            status.response   = best_reg.response;
        end
    end

    assign q_load  = (state_reg == ST_FIN);
    assign q_batch = {1'b1, batch_reg.vld[1:0], status, batch_reg.item[1], batch_reg.item[0]};

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        prev_valid_next = prev_valid_reg;
        prev_ident_next = prev_ident_reg;
        seg_begin_next  = seg_begin_reg;
        started_next    = started_reg;
        finished_next   = finished_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        unf_cnt_next    = unf_cnt_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        done_next       = done_reg;
        all_done_next   = all_done_reg;
        batch_next      = batch_reg;
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = rec_new;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == FUNC_LOAD)
                    begin
                        if (slot_ok)
                        begin
                            wr_en             = 1'b1;
                            wr_addr           = slot_wide[IW-1:0];
                            wr_data.ident     = in_ident;
                            wr_data.arrival   = in_arrival;
                            wr_data.period    = in_period;
                            wr_data.burst     = in_burst;
                            wr_data.remaining = in_burst;
                            wr_data.response  = 16'd0;
                            started_next[slot_wide[IW-1:0]]  = 1'b0;
                            finished_next[slot_wide[IW-1:0]] = 1'b0;
                            now_next        = '0;
                            prev_valid_next = 1'b0;
                            seg_begin_next  = '0;
                        end
                    end
                    else
                    begin
                        scan_cnt_next = '0;
                        unf_cnt_next  = '0;
                        found_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                cmp_vld_next = issue;
                cmp_idx_next = scan_cnt_reg[IW-1:0];
                if (issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNTW'(1);
                end
                if (cmp_vld_reg && cmp_unf)
                begin
                    unf_cnt_next = unf_cnt_reg + CNTW'(1);
                end
                if (better)
                begin
                    found_next    = 1'b1;
                    best_next     = rd_data_reg;
                    best_idx_next = cmp_idx_reg;
                end
                if (!issue)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                now_next            = now_inc;
                batch_next.vld[0]   = seg_a_vld;
                batch_next.item[0]  = seg_a;
                batch_next.vld[1]   = done_now;
                batch_next.item[1]  = seg_b;
                done_next           = done_now;
                // the winner is unfinished, so it is among the counted ones
                all_done_next = (unf_cnt_reg == '0)
                                || ((unf_cnt_reg == CNTW'(1)) && done_now);
                if (found_reg)
                begin
                    prev_valid_next = !done_now;
                    prev_ident_next = best_reg.ident;
                    seg_begin_next  = seg_begin_run;
                    started_next[best_idx_reg] = 1'b1;
                    if (done_now)
                    begin
                        finished_next[best_idx_reg] = 1'b1;
                    end
                    wr_en     = 1'b1;
                    best_next = rec_new;
                end
                else
                begin
                    prev_valid_next = 1'b0;
                end
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                state_next = ST_DRAIN;
            end

            ST_DRAIN:
            begin
                if (q_drained)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            task_count_reg <= 5'd0;
            now_reg        <= '0;
            prev_valid_reg <= 1'b0;
            prev_ident_reg <= 8'd0;
            seg_begin_reg  <= '0;
            started_reg    <= '0;
            finished_reg   <= '0;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            unf_cnt_reg    <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            done_reg       <= 1'b0;
            all_done_reg   <= 1'b0;
            batch_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                task_count_reg <= cfg_wr_data;
            end
            now_reg        <= now_next;
            prev_valid_reg <= prev_valid_next;
            prev_ident_reg <= prev_ident_next;
            seg_begin_reg  <= seg_begin_next;
            started_reg    <= started_next;
            finished_reg   <= finished_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            unf_cnt_reg    <= unf_cnt_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            done_reg       <= done_next;
            all_done_reg   <= all_done_next;
            batch_reg      <= batch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    rmts_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (q_load),
        .batch    (q_batch),
        .drained  (q_drained),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
